// ===== design/wcse_pkg.sv =====
// ----------------------------------------------------------------------------
// wcse_pkg
// Shared types and constants for the wave container sample extractor.
// ----------------------------------------------------------------------------
package wcse_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] FMT_PCM   = 16'd1;
    localparam logic [15:0] FMT_FLOAT = 16'd3;

    localparam logic [31:0] FMT_BODY_BYTES = 32'd16;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_ERROR  = 2'd2
    } result_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_NOT_WAVE    = 3'd1,
        ERR_FMT_SHORT   = 3'd2,
        ERR_UNSUPPORTED = 3'd3,
        ERR_NO_FMT      = 3'd4,
        ERR_TRUNCATED   = 3'd5
    } error_code_t;

    typedef enum logic [8:0] {
        PH_RIFF  = 9'b000000001,
        PH_RSIZE = 9'b000000010,
        PH_WAVE  = 9'b000000100,
        PH_CID   = 9'b000001000,
        PH_CSIZE = 9'b000010000,
        PH_FMT   = 9'b000100000,
        PH_SKIP  = 9'b001000000,
        PH_DATA  = 9'b010000000,
        PH_DONE  = 9'b100000000
    } phase_t;

    typedef struct packed {
        result_kind_t result_kind;
        error_code_t  error_code;
        logic [31:0]  sample_value;
        logic         sample_is_float;
        logic [15:0]  channel_index;
        logic         frame_last;
        logic         data_last;
        logic [15:0]  channel_total;
        logic [31:0]  rate_hz;
        logic [5:0]   bits_each;
    } result_t;

endpackage

// ===== design/wave_container_sample_extractor.sv =====
// ----------------------------------------------------------------------------
// wave_container_sample_extractor
// RIFF/WAVE byte stream parser giving header, Q1.31 / float32 samples, errors.
// ----------------------------------------------------------------------------
//  channel   ports                                  item
//  input     s_valid s_ready s_in_byte s_stream_end  one file byte
//  result    m_valid m_ready m_result_kind ...       header, sample or error
//
//  one byte per cycle unless stalled; each byte is parsed in the cycle it is
//  taken and its result, if any, lands in the output register on the same edge
//  s_ready stays high while the output register is empty or being drained
//  a stalled result blocks only new bytes, never the one already held
//  aresetn clears the parse state to wait for the riff tag
// ----------------------------------------------------------------------------
module wave_container_sample_extractor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_stream_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [2:0]  m_error_code,
    output logic signed [31:0] m_sample_value,
    output logic        m_sample_is_float,
    output logic [15:0] m_channel_index,
    output logic        m_frame_last,
    output logic        m_data_last,
    output logic [15:0] m_channel_total,
    output logic [31:0] m_rate_hz,
    output logic [5:0]  m_bits_each
);
    import wcse_pkg::*;

    logic    byte_take;
    logic    res_valid;
    result_t res;
    logic    out_valid_reg;
    result_t out_reg;

    assign s_ready   = !out_valid_reg || m_ready;
    assign byte_take = s_valid && s_ready;

    wcse_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_take  (byte_take),
        .in_byte    (s_in_byte),
        .stream_end (s_stream_end),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_ready) begin
            out_valid_reg <= byte_take && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_take && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_result_kind     = out_reg.result_kind;
    assign m_error_code      = out_reg.error_code;
    assign m_sample_value    = out_reg.sample_value;
    assign m_sample_is_float = out_reg.sample_is_float;
    assign m_channel_index   = out_reg.channel_index;
    assign m_frame_last      = out_reg.frame_last;
    assign m_data_last       = out_reg.data_last;
    assign m_channel_total   = out_reg.channel_total;
    assign m_rate_hz         = out_reg.rate_hz;
    assign m_bits_each       = out_reg.bits_each;

endmodule

// ===== design/wcse_parser.sv =====
// ----------------------------------------------------------------------------
// wcse_parser
// Byte-wise RIFF/WAVE chunk walker and PCM frame slicer; at most one result per byte.
// ----------------------------------------------------------------------------
module wcse_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_take,
    input  logic [7:0]        in_byte,
    input  logic              stream_end,
    output logic              res_valid,
    output wcse_pkg::result_t res
);
    import wcse_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  fbc_reg, fbc_next;
    logic [31:0] shift_reg, shift_next;
    logic        tag_fmt_reg, tag_fmt_next;
    logic        tag_data_reg, tag_data_next;
    logic [31:0] left_reg, left_next;
    logic [15:0] fmt_code_reg, fmt_code_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic        fmt_seen_reg, fmt_seen_next;
    logic [1:0]  bis_reg, bis_next;
    logic [15:0] chcnt_reg, chcnt_next;
    logic [17:0] fbs_reg, fbs_next;

    logic [31:0] shift_in;
    logic [2:0]  bps;
    logic [17:0] fbs_new;
    logic [31:0] left_dec;
    logic [16:0] ch_inc;
    logic        flast;
    logic        fmt_ok;

    always_comb begin
        shift_in = {in_byte, shift_reg[31:8]};
        bps      = bits_reg[5:3];
        fbs_new  = {2'b00, chan_reg} * {15'd0, bps};
        left_dec = left_reg - 32'd1;
        ch_inc   = {1'b0, chcnt_reg} + 17'd1;
        flast    = ch_inc >= {1'b0, chan_reg};
        fmt_ok   = ((fmt_code_reg == FMT_PCM) && ((shift_in[31:16] == 16'd16)
                    || (shift_in[31:16] == 16'd24) || (shift_in[31:16] == 16'd32)))
                   || ((fmt_code_reg == FMT_FLOAT) && (shift_in[31:16] == 16'd32));

        phase_next    = phase_reg;
        fbc_next      = fbc_reg;
        shift_next    = shift_reg;
        tag_fmt_next  = tag_fmt_reg;
        tag_data_next = tag_data_reg;
        left_next     = left_reg;
        fmt_code_next = fmt_code_reg;
        chan_next     = chan_reg;
        rate_next     = rate_reg;
        bits_next     = bits_reg;
        fmt_seen_next = fmt_seen_reg;
        bis_next      = bis_reg;
        chcnt_next    = chcnt_reg;
        fbs_next      = fbs_reg;
        res_valid     = 1'b0;
        res           = '0;

        case (phase_reg)
            PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID, PH_CSIZE: begin
                shift_next = shift_in;
                if (fbc_reg < 4'd3) begin
                    fbc_next = fbc_reg + 4'd1;
                end else begin
                    fbc_next = '0;
                    case (phase_reg)
                        PH_RIFF: begin
                            if (shift_in != TAG_RIFF) begin
                                res_valid      = 1'b1;
                                res.result_kind = KIND_ERROR;
                                res.error_code  = ERR_NOT_WAVE;
                                phase_next     = PH_DONE;
                            end else begin
                                phase_next = PH_RSIZE;
                            end
                        end
                        PH_RSIZE: begin
                            phase_next = PH_WAVE;
                        end
                        PH_WAVE: begin
                            if (shift_in != TAG_WAVE) begin
                                res_valid      = 1'b1;
                                res.result_kind = KIND_ERROR;
                                res.error_code  = ERR_NOT_WAVE;
                                phase_next     = PH_DONE;
                            end else begin
                                phase_next = PH_CID;
                            end
                        end
                        PH_CID: begin
                            tag_fmt_next  = shift_in == TAG_FMT;
                            tag_data_next = shift_in == TAG_DATA;
                            phase_next    = PH_CSIZE;
                        end
                        default: begin
                            // chunk size complete
                            if (tag_fmt_reg) begin
                                if (shift_in < FMT_BODY_BYTES) begin
                                    res_valid      = 1'b1;
                                    res.result_kind = KIND_ERROR;
                                    res.error_code  = ERR_FMT_SHORT;
                                    phase_next     = PH_DONE;
                                end else begin
                                    left_next  = shift_in;
                                    phase_next = PH_FMT;
                                end
                            end else if (tag_data_reg) begin
                                if (!fmt_seen_reg || (chan_reg == 16'd0)) begin
                                    res_valid      = 1'b1;
                                    res.result_kind = KIND_ERROR;
                                    res.error_code  = ERR_NO_FMT;
                                    phase_next     = PH_DONE;
                                end else begin
                                    fbs_next          = fbs_new;
                                    left_next         = shift_in;
                                    bis_next          = '0;
                                    chcnt_next        = '0;
                                    res_valid         = 1'b1;
                                    res.result_kind   = KIND_HEADER;
                                    res.channel_total = chan_reg;
                                    res.rate_hz       = rate_reg;
                                    res.bits_each     = bits_reg[5:0];
                                    phase_next = (shift_in < {14'd0, fbs_new}) ? PH_DONE
                                                                               : PH_DATA;
                                end
                            end else begin
                                left_next  = shift_in;
                                phase_next = (shift_in != 32'd0) ? PH_SKIP : PH_CID;
                            end
                        end
                    endcase
                end
            end
            PH_FMT: begin
                shift_next = shift_in;
                case (fbc_reg)
                    4'd1:    fmt_code_next = shift_in[31:16];
                    4'd3:    chan_next     = shift_in[31:16];
                    4'd7:    rate_next     = shift_in;
                    4'd15:   bits_next     = shift_in[31:16];
                    default: ;
                endcase
                if (fbc_reg != 4'd15) begin
                    fbc_next = fbc_reg + 4'd1;
                end else begin
                    fbc_next = '0;
                    if (!fmt_ok) begin
                        res_valid      = 1'b1;
                        res.result_kind = KIND_ERROR;
                        res.error_code  = ERR_UNSUPPORTED;
                        phase_next     = PH_DONE;
                    end else begin
                        fmt_seen_next = 1'b1;
                        left_next     = left_reg - FMT_BODY_BYTES;
                        phase_next    = (left_reg != FMT_BODY_BYTES) ? PH_SKIP : PH_CID;
                    end
                end
            end
            PH_SKIP: begin
                left_next = left_dec;
                if (left_dec == 32'd0) begin
                    phase_next = PH_CID;
                end
            end
            PH_DATA: begin
                shift_next = (bis_reg == 2'd0) ? {in_byte, 24'd0} : shift_in;
                left_next  = left_dec;
                if (({1'b0, bis_reg} + 3'd1) < bps) begin
                    bis_next = bis_reg + 2'd1;
                end else begin
                    bis_next            = '0;
                    chcnt_next          = flast ? 16'd0 : ch_inc[15:0];
                    res_valid           = 1'b1;
                    res.result_kind     = KIND_SAMPLE;
                    res.sample_value    = shift_next;
                    res.sample_is_float = fmt_code_reg == FMT_FLOAT;
                    res.channel_index   = chcnt_reg;
                    res.frame_last      = flast;
                    res.data_last       = flast && (left_dec < {14'd0, fbs_reg});
                    if (res.data_last) begin
                        phase_next = PH_DONE;
                    end
                end
            end
            default: begin
                phase_next = PH_DONE;
            end
        endcase

        if (stream_end) begin
            if (phase_next != PH_DONE) begin
                res_valid       = 1'b1;
                res             = '0;
                res.result_kind = KIND_ERROR;
                res.error_code  = ERR_TRUNCATED;
            end
            phase_next    = PH_RIFF;
            fbc_next      = '0;
            fmt_seen_next = 1'b0;
            bis_next      = '0;
            chcnt_next    = '0;
            chan_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_RIFF;
            fbc_reg      <= '0;
            fmt_seen_reg <= 1'b0;
            bis_reg      <= '0;
            chcnt_reg    <= '0;
            chan_reg     <= '0;
        end else if (byte_take) begin
            phase_reg    <= phase_next;
            fbc_reg      <= fbc_next;
            fmt_seen_reg <= fmt_seen_next;
            bis_reg      <= bis_next;
            chcnt_reg    <= chcnt_next;
            chan_reg     <= chan_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_take) begin
            shift_reg    <= shift_next;
            tag_fmt_reg  <= tag_fmt_next;
            tag_data_reg <= tag_data_next;
            left_reg     <= left_next;
            fmt_code_reg <= fmt_code_next;
            rate_reg     <= rate_next;
            bits_reg     <= bits_next;
            fbs_reg      <= fbs_next;
        end
    end

endmodule
